>>> rtl/core/vrra_pkg.sv
// package for the variable record ring allocator: sizes, codes, beat and
// controller/datapath interface types; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vrra_pkg;

    localparam int MAX_CAPACITY_BYTES = 4096;
    localparam int MIN_CAPACITY_BYTES = 32;
    localparam int HEADER_BYTES       = 16;

    localparam int OFF_W      = $clog2(MAX_CAPACITY_BYTES);
    localparam int CNT_W      = OFF_W + 1;
    localparam int SUM_W      = CNT_W + 1;
    localparam int SLOT_COUNT = MAX_CAPACITY_BYTES / 4;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LEN_W      = 12;
    localparam int PAYLOAD_W  = 12;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic                 req_type;
        logic [PAYLOAD_W-1:0] payload_bytes;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] record_offset;
        logic [LEN_W-1:0] record_bytes;
        logic [CNT_W-1:0] used_bytes;
    } t_result;

    typedef struct packed {
        logic load;
        logic reject;
        logic mark_wrap;
        logic push_commit;
        logic fetch_head;
        logic pop_commit;
        logic pop_wrapped;
    } t_cmd;

    typedef struct packed {
        logic is_pop;
        logic reject;
        logic wrap;
        logic marker;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/core/vrra_ctrl.sv
// sequencing state machine for the ring allocator
// depends on vrra_pkg for command and status types
`timescale 1ns / 1ps
`default_nettype none

module vrra_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  vrra_pkg::t_dp_status  i_sts,
    output vrra_pkg::t_cmd        o_cmd,
    output logic                  o_busy
);
    import vrra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WRAP = 4'b0100,
        S_POP0 = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.reject) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_IDLE;
                end else if (!i_sts.is_pop) begin
                    if (i_sts.wrap) begin
                        // marker first, record at slot zero next cycle
                        o_cmd.mark_wrap = 1'b1;
                        n_state         = S_WRAP;
                    end else begin
                        o_cmd.push_commit = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (i_sts.marker) begin
                    o_cmd.fetch_head = 1'b1;
                    n_state          = S_POP0;
                end else begin
                    o_cmd.pop_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_WRAP: begin
                o_cmd.push_commit = 1'b1;
                n_state           = S_IDLE;
            end
            S_POP0: begin
                o_cmd.pop_commit  = 1'b1;
                o_cmd.pop_wrapped = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/vrra_dp.sv
// datapath: capacity, ring pointers, used count, length memory, result register
// depends on vrra_pkg
`timescale 1ns / 1ps
`default_nettype none

module vrra_dp (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  vrra_pkg::t_req           i_req,
    input  vrra_pkg::t_cmd           i_cmd,
    input  wire                      i_cfg_we,
    input  wire [vrra_pkg::CNT_W-1:0] i_cfg_data,
    output vrra_pkg::t_dp_status     o_sts,
    output logic [vrra_pkg::CNT_W-1:0] o_capacity,
    output vrra_pkg::t_result        o_result,
    output logic                     o_result_valid
);
    import vrra_pkg::*;

    logic [LEN_W-1:0] r_mem [SLOT_COUNT];

    logic [CNT_W-1:0] r_capacity, n_capacity;
    logic [OFF_W-1:0] r_write_offset;
    logic [OFF_W-1:0] r_read_offset;
    logic [CNT_W-1:0] r_used;
    t_req             r_req;
    logic [LEN_W-1:0] r_rd;
    t_result          r_result, n_result;
    logic             r_valid;

    logic [CNT_W-1:0] w_len, w_alloc, w_tail, w_free;
    logic [SUM_W-1:0] w_need, w_used_push;
    logic             w_no_wrap, w_too_large, w_full;
    t_status          w_push_status;
    logic [OFF_W-1:0] w_push_off, w_wo_next;
    logic [CNT_W-1:0] w_rd_round, w_rtail;
    logic [SUM_W-1:0] w_pop_amt;
    logic [OFF_W-1:0] w_ro_next;
    logic [CNT_W-1:0] w_used_pop;
    logic             w_emit;
    logic             w_we;
    logic [SLOT_W-1:0] w_waddr, w_raddr;
    logic [LEN_W-1:0] w_wdata;

    // one wrap back into the ring, anything still beyond goes to zero
    function automatic logic [OFF_W-1:0] ring_wrap(input logic [SUM_W-1:0] s,
                                                   input logic [CNT_W-1:0] cap);
        logic [SUM_W-1:0] t;
        t = s;
        if (t >= {1'b0, cap}) t = t - {1'b0, cap};
        if (t >= {1'b0, cap}) t = '0;
        return t[OFF_W-1:0];
    endfunction

    // push arithmetic
    always_comb begin
        w_len       = CNT_W'(HEADER_BYTES) + CNT_W'(r_req.payload_bytes);
        w_alloc     = (w_len + CNT_W'(3)) & ~CNT_W'(3);
        w_tail      = (CNT_W'(r_write_offset) < r_capacity)
                      ? r_capacity - CNT_W'(r_write_offset) : '0;
        w_free      = (r_used <= r_capacity) ? r_capacity - r_used : '0;
        w_too_large = (w_alloc >= r_capacity);
        w_no_wrap   = (w_tail >= w_alloc);
        w_need      = w_no_wrap ? SUM_W'(w_alloc) : SUM_W'(w_alloc) + SUM_W'(w_tail);
        w_full      = (SUM_W'(w_free) < w_need);
        if (w_too_large) begin
            w_push_status = ST_TOO_LARGE;
        end else if (w_full) begin
            w_push_status = ST_FULL;
        end else begin
            w_push_status = ST_OK;
        end
        w_push_off  = w_no_wrap ? r_write_offset : '0;
        w_wo_next   = ring_wrap(SUM_W'(r_write_offset) + w_need, r_capacity);
        w_used_push = SUM_W'(r_used) + w_need;
    end

    // pop arithmetic, r_rd holds the length read at the read offset or slot zero
    always_comb begin
        w_rd_round = (CNT_W'(r_rd) + CNT_W'(3)) & ~CNT_W'(3);
        w_rtail    = (CNT_W'(r_read_offset) < r_capacity)
                     ? r_capacity - CNT_W'(r_read_offset) : '0;
        w_pop_amt  = SUM_W'(w_rd_round) + (i_cmd.pop_wrapped ? SUM_W'(w_rtail) : '0);
        w_ro_next  = ring_wrap(SUM_W'(r_read_offset) + w_pop_amt, r_capacity);
        w_used_pop = (w_pop_amt > SUM_W'(r_used))
                     ? '0 : CNT_W'(SUM_W'(r_used) - w_pop_amt);
    end

    always_comb begin
        o_sts.is_pop = (r_req.req_type == REQ_POP);
        o_sts.reject = o_sts.is_pop ? (r_used == '0) : (w_push_status != ST_OK);
        o_sts.wrap   = !w_no_wrap;
        o_sts.marker = (r_rd == '0);
    end

    always_comb begin
        n_capacity = i_cfg_data & ~CNT_W'(3);
        if (n_capacity < CNT_W'(MIN_CAPACITY_BYTES)) begin
            n_capacity = CNT_W'(MIN_CAPACITY_BYTES);
        end else if (n_capacity > CNT_W'(MAX_CAPACITY_BYTES)) begin
            n_capacity = CNT_W'(MAX_CAPACITY_BYTES);
        end
    end

    // length memory port selection
    always_comb begin
        w_we    = i_cmd.mark_wrap | i_cmd.push_commit;
        w_waddr = (i_cmd.push_commit && !w_no_wrap)
                  ? '0 : r_write_offset[OFF_W-1:2];
        w_wdata = i_cmd.mark_wrap ? '0 : w_len[LEN_W-1:0];
        w_raddr = i_cmd.fetch_head ? '0 : r_read_offset[OFF_W-1:2];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= CNT_W'(MAX_CAPACITY_BYTES);
            r_write_offset <= '0;
            r_read_offset  <= '0;
            r_used         <= '0;
        end else if (i_cfg_we) begin
            r_capacity     <= n_capacity;
            r_write_offset <= '0;
            r_read_offset  <= '0;
            r_used         <= '0;
        end else if (i_cmd.push_commit) begin
            r_write_offset <= w_wo_next;
            r_used         <= w_used_push[CNT_W-1:0];
        end else if (i_cmd.pop_commit) begin
            r_read_offset  <= w_ro_next;
            r_used         <= w_used_pop;
        end
    end

    assign w_emit = i_cmd.reject | i_cmd.push_commit | i_cmd.pop_commit;

    always_comb begin
        n_result            = '0;
        n_result.status     = ST_OK;
        n_result.used_bytes = r_used;
        if (i_cmd.reject) begin
            n_result.status = o_sts.is_pop ? ST_EMPTY : w_push_status;
        end else if (i_cmd.push_commit) begin
            n_result.record_offset = w_push_off;
            n_result.record_bytes  = w_len[LEN_W-1:0];
            n_result.used_bytes    = w_used_push[CNT_W-1:0];
        end else if (i_cmd.pop_commit) begin
            n_result.record_offset = i_cmd.pop_wrapped ? '0 : r_read_offset;
            n_result.record_bytes  = r_rd;
            n_result.used_bytes    = w_used_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_emit;
        end
    end

    assign o_capacity     = r_capacity;
    assign o_result       = r_result;
    assign o_result_valid = r_valid;

    a_used_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_capacity)
        else $error("used count beyond capacity");

    a_offsets_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_write_offset) < r_capacity) && (CNT_W'(r_read_offset) < r_capacity))
        else $error("ring offset beyond capacity");

    a_offsets_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_write_offset[1:0] == 2'b00) && (r_read_offset[1:0] == 2'b00))
        else $error("ring offset not word aligned");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_result.status != ST_OK))
        |-> ((r_result.record_offset == '0) && (r_result.record_bytes == '0)))
        else $error("refused request carries a record");

endmodule

`default_nettype wire

>>> rtl/core/variable_record_ring_allocator.sv
// top level of the variable record ring allocator: register port and glue
// depends on vrra_pkg, vrra_ctrl and vrra_dp
//
//  channel   handshake                         payload
//  request   start && !busy                    i_req (t_req)
//  result    o_result_valid, one cycle         o_result (t_result)
//  config    psel && penable && pwrite         paddr, pwdata, prdata
//
// push: 2 cycles from accept to result, 3 when a wrap marker is written first
// pop: 2 cycles, 3 when a wrap marker is met and slot zero must be read
// the length memory's single write port and registered read set these figures
// a new request is taken in the cycle its predecessor's result is shown
// synchronous active-low reset empties the ring and sets capacity to 4096
// results cannot be stalled; the length memory needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module variable_record_ring_allocator (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  vrra_pkg::t_req                  i_req,
    output vrra_pkg::t_result               o_result,
    output logic                            o_result_valid,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [vrra_pkg::PADDR_W-1:0]     paddr,
    input  wire [vrra_pkg::PDATA_W-1:0]     pwdata,
    output logic [vrra_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import vrra_pkg::*;

    t_cmd             w_cmd;
    t_dp_status       w_sts;
    logic [CNT_W-1:0] w_capacity;
    logic             w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite & (paddr[2] == REG_CAPACITY);
    assign prdata   = (paddr[2] == REG_CAPACITY) ? PDATA_W'(w_capacity) : '0;

    vrra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    vrra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cmd          (w_cmd),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_data     (pwdata[CNT_W-1:0]),
        .o_sts          (w_sts),
        .o_capacity     (w_capacity),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire
